// ===== hw/rtl/gf2at_pkg.sv =====
`default_nettype none

package gf2at_pkg;

    // Fixed field widths of the request and result channels
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned INDEX_W  = 5;
    localparam int unsigned NARROW_W = 8;

    // Configuration port: two 32-bit registers at 4-byte spacing
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register select, taken from paddr above the byte offset
    typedef enum logic [0:0] {
        REG_OFFSET = 1'b0,
        REG_NARROW = 1'b1
    } reg_sel_t;

    // Request command
    typedef enum logic [0:0] {
        CMD_LOAD  = 1'b0,
        CMD_XFORM = 1'b1
    } cmd_t;

    // Configuration handed from the register block to the datapath
    typedef struct packed {
        logic [DATA_W-1:0] offset_vector;
        logic              narrow_mode;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gf2at_regs.sv =====
`default_nettype none

module gf2at_regs
    import gf2at_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [DATA_W-1:0] offset_reg;
    logic [DATA_W-1:0] offset_next;
    logic              narrow_reg;
    logic              narrow_next;
    logic              wr_en;
    reg_sel_t          sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = reg_sel_t'(paddr[APB_ADDR_W-1:2]);

    // Write decode
    always_comb
    begin
        offset_next = offset_reg;
        narrow_next = narrow_reg;
        if (wr_en)
        begin
            unique case (sel)
                REG_OFFSET: offset_next = pwdata[DATA_W-1:0];
                REG_NARROW: narrow_next = pwdata[0];
                default:    offset_next = offset_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            narrow_reg <= 1'b0;
        end
        else
        begin
            offset_reg <= offset_next;
            narrow_reg <= narrow_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (sel)
            REG_OFFSET: prdata = offset_reg;
            REG_NARROW: prdata = {{(APB_DATA_W-1){1'b0}}, narrow_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.offset_vector = offset_reg;
    assign cfg.narrow_mode   = narrow_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gf2at_matrix.sv =====
`default_nettype none

module gf2at_matrix
    import gf2at_pkg::*;
#(
    parameter int unsigned WIDTH = 32
)
(
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [INDEX_W-1:0] wr_idx,
    input  wire logic [DATA_W-1:0]  wr_data,
    input  wire logic [DATA_W-1:0]  vec,
    input  wire logic               narrow,
    output logic      [WIDTH-1:0]   product
);

    logic [WIDTH-1:0] rows [WIDTH];
    logic [WIDTH-1:0] vec_w;
    logic [WIDTH-1:0] prod_wide;
    logic [WIDTH-1:0] prod_narrow;

    assign vec_w = WIDTH'(vec);

    // Row storage: only rows reachable by a 5-bit index are writable
    for (genvar r = 0; r < WIDTH; r++)
    begin : g_row
        if (r < (1 << INDEX_W))
        begin : g_store
            always_ff @(posedge clk)
            begin
                if (wr_en && (wr_idx == INDEX_W'(r)))
                begin
                    rows[r] <= WIDTH'(wr_data);
                end
            end
        end
        else
        begin : g_zero
            assign rows[r] = '0;
        end

        // Row parity; row 0 lands in the top bit
        assign prod_wide[WIDTH-1-r] = ^(rows[r] & vec_w);
    end

    // 8 by 8 map from the low corner of the matrix
    for (genvar n = 0; n < WIDTH; n++)
    begin : g_narrow
        if (n < NARROW_W)
        begin : g_bit
            assign prod_narrow[NARROW_W-1-n] =
                ^(rows[n][NARROW_W-1:0] & vec[NARROW_W-1:0]);
        end
        else
        begin : g_pad
            assign prod_narrow[n] = 1'b0;
        end
    end

    assign product = narrow ? prod_narrow : prod_wide;

endmodule

`default_nettype wire

// ===== hw/rtl/gf2_affine_transform_unit.sv =====
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  cmd, row_index, data
// result    out        out_valid/ out_stall result
// config    in         APB write/read       offset_vector (0x0), narrow_mode (0x4)
//
// One request per cycle while in_stall is low; a transform result passes through
// the input register and then the result register around the row-parity array.
// A load writes its row in the cycle after acceptance and produces no result.
// Reset clears control and the config registers; matrix rows hold no reset
// value until written. in_stall rises only while a transform waits behind a
// stalled result.
`default_nettype none

module gf2_affine_transform_unit
    import gf2at_pkg::*;
#(
    parameter int unsigned WIDTH = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  cmd,
    input  wire logic [INDEX_W-1:0]    row_index,
    input  wire logic [DATA_W-1:0]     data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [DATA_W-1:0]     result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t               cfg;
    logic               in_accept;
    logic               out_free;
    logic               s1_move;
    logic               s1_xform;
    logic [WIDTH-1:0]   product;
    logic [WIDTH-1:0]   offset_w;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    cmd_t               s1_cmd_reg;
    logic [INDEX_W-1:0] s1_idx_reg;
    logic [DATA_W-1:0]  s1_data_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DATA_W-1:0]  result_reg;
    logic [DATA_W-1:0]  result_next;

    gf2at_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage 1 control: loads always retire, transforms need the result slot
    assign s1_xform  = (s1_cmd_reg == CMD_XFORM);
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && (!s1_xform || out_free);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_accept = in_valid && !in_stall;

    gf2at_matrix #(
        .WIDTH (WIDTH)
    ) u_matrix (
        .clk     (clk),
        .wr_en   (s1_valid_reg && !s1_xform),
        .wr_idx  (s1_idx_reg),
        .wr_data (s1_data_reg),
        .vec     (s1_data_reg),
        .narrow  (cfg.narrow_mode),
        .product (product)
    );

    // Offset add over GF(2)
    assign offset_w = cfg.narrow_mode ? WIDTH'(cfg.offset_vector[NARROW_W-1:0])
                                      : WIDTH'(cfg.offset_vector);

    always_comb
    begin
        s1_valid_next = s1_valid_reg && !s1_move;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg && out_stall;
        result_next    = result_reg;
        if (s1_move && s1_xform)
        begin
            out_valid_next = 1'b1;
            result_next    = DATA_W'(product ^ offset_w);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg  <= cmd_t'(cmd);
            s1_idx_reg  <= row_index;
            s1_data_reg <= data;
        end
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // A load with the slot free leaves no result behind
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_xform && out_free) |=> !out_valid)
        else $error("load request produced a result");

    // A retiring transform always shows up at the output
    a_xform_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_xform) |=> out_valid)
        else $error("transform result lost");

    // Input backpressure only from a transform blocked behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_xform && out_valid_reg && out_stall))
        else $error("spurious input stall");

    // Narrow map keeps the upper result bits clear
    a_narrow_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_xform && cfg.narrow_mode) |=> (result[DATA_W-1:NARROW_W] == '0))
        else $error("narrow result has upper bits set");

endmodule

`default_nettype wire

// ===== sim/gf2_affine_transform_unit_test.sv =====
`default_nettype none

module gf2_affine_transform_unit_test;
    import gf2at_pkg::*;

    localparam int unsigned ROWS         = 32;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned PHASE_ITEMS  = 260;
    localparam int unsigned BURST_ITEMS  = 48;

    // Directed rows: extremes, single bits, upper-only and lower-only patterns
    localparam logic [DATA_W-1:0] EDGE_ROWS [NARROW_W] = '{
        32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0080, 32'h0000_0001,
        32'hAAAA_AA55, 32'h5555_55AA, 32'hFFFF_FF00, 32'h0000_00FF
    };
    localparam logic [DATA_W-1:0] EDGE_WORDS [5] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0080, 32'hFFFF_FF00
    };

    // Expected-result tracking: matrix copy, config copy, pending words
    class affine_scoreboard;
        logic [DATA_W-1:0] matrix [ROWS];
        bit                row_loaded [ROWS];
        logic [DATA_W-1:0] offset_vector;
        bit                narrow_mode;
        logic [DATA_W-1:0] expected_words [$];
        int unsigned       errors;
        int unsigned       loads;
        int unsigned       transforms;
        int unsigned       matched;

        function new();
            offset_vector = '0;
            narrow_mode   = 1'b0;
            errors        = 0;
            loads         = 0;
            transforms    = 0;
            matched       = 0;
            foreach (row_loaded[i])
                row_loaded[i] = 1'b0;
        endfunction

        function void set_config(reg_sel_t sel, logic [APB_DATA_W-1:0] value);
            if (sel == REG_OFFSET)
                offset_vector = value;
            else
                narrow_mode = value[0];
        endfunction

        // Narrow map needs rows 0..7, the wide map every row
        function bit rows_ready();
            int unsigned need;
            need = narrow_mode ? NARROW_W : ROWS;
            for (int i = 0; i < need; i++)
                if (!row_loaded[i])
                    return 1'b0;
            return 1'b1;
        endfunction

        // Row i parity lands in bit (width-1-i) of the active width, row 0 in the top bit
        function logic [DATA_W-1:0] affine_map(logic [DATA_W-1:0] vec);
            logic [DATA_W-1:0] acc;
            acc = '0;
            if (narrow_mode)
            begin
                for (int i = 0; i < NARROW_W; i++)
                    acc[NARROW_W-1-i] = ^(matrix[i][NARROW_W-1:0] & vec[NARROW_W-1:0]);
                acc[NARROW_W-1:0] = acc[NARROW_W-1:0] ^ offset_vector[NARROW_W-1:0];
            end
            else
            begin
                for (int i = 0; i < ROWS; i++)
                    acc[DATA_W-1-i] = ^(matrix[i] & vec);
                acc = acc ^ offset_vector;
            end
            return acc;
        endfunction

        function void note_request(cmd_t c, logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] d);
            if (c == CMD_LOAD)
            begin
                matrix[idx]     = d;
                row_loaded[idx] = 1'b1;
                loads++;
            end
            else
            begin
                expected_words.push_back(affine_map(d));
                transforms++;
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got !== want)
            begin
                $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
                errors++;
            end
            else
                matched++;
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction

        function void report_leftover();
            if (expected_words.size() != 0)
            begin
                $display("%0t: %0d results never arrived, expected %h first, actual none",
                         $time, expected_words.size(), expected_words[0]);
                errors += expected_words.size();
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  cmd;
    logic [INDEX_W-1:0]    row_index;
    logic [DATA_W-1:0]     data;
    logic                  out_valid;
    logic                  out_stall;
    logic [DATA_W-1:0]     result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bit                    idle_on      = 1'b1;
    bit                    hold_request = 1'b0;
    int unsigned           phases_run   = 0;
    affine_scoreboard      board        = new();

    gf2_affine_transform_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .row_index (row_index),
        .data      (data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            3:       return ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
            default: return $urandom();
        endcase
    endfunction

    // Result-side stall pattern; a hold request overrides it immediately
    initial
    begin : result_stall_driver
        int unsigned busy_left;
        int unsigned free_left;
        busy_left = 0;
        free_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                busy_left    = HOLD_CYCLES;
                free_left    = 0;
            end
            else if (busy_left == 0 && free_left == 0)
            begin
                busy_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
                free_left = pick_gap() + $urandom_range(0, 8);
            end
            if (busy_left != 0)
            begin
                out_stall <= 1'b1;
                busy_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (free_left != 0)
                    free_left--;
            end
        end
    end

    // Result check at each accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(result);
    end

    // One APB transfer: setup cycle, then access until pready
    task automatic apb_access(bit wr, reg_sel_t sel, logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write a register, mirror it, then read it back
    task automatic write_register(reg_sel_t sel, logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] mask;
        logic [APB_DATA_W-1:0] readback;
        mask = '1;
        if (sel == REG_NARROW)
            mask = APB_DATA_W'(1);
        apb_access(1'b1, sel, value, readback);
        board.set_config(sel, value);
        apb_access(1'b0, sel, '0, readback);
        if ((readback & mask) !== (value & mask))
        begin
            $display("%0t: register %s readback, expected %h, actual %h",
                     $time, sel.name(), value & mask, readback & mask);
            board.errors++;
        end
    endtask

    // Offer one request after a gap and hold it until accepted
    task automatic send_request(cmd_t c, logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] d,
                                int unsigned gap);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        row_index <= idx;
        data      <= d;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(c, idx, d);
    endtask

    task automatic end_requests();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Transforms only once every row they read has been loaded
    task automatic send_random_item();
        logic [DATA_W-1:0] word;
        word = pick_word();
        if (board.rows_ready() && $urandom_range(0, 9) < 7)
            send_request(CMD_XFORM, INDEX_W'($urandom_range(0, ROWS - 1)), word, pick_gap());
        else
            send_request(CMD_LOAD, INDEX_W'($urandom_range(0, ROWS - 1)), word, pick_gap());
    endtask

    task automatic wait_idle();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One configuration setting followed by random traffic
    task automatic run_phase(logic [DATA_W-1:0] offset, logic [APB_DATA_W-1:0] narrow_word,
                             bit idling, bit squeeze);
        wait_idle();
        idle_on = idling;
        write_register(REG_OFFSET, offset);
        write_register(REG_NARROW, narrow_word);
        for (int i = 0; i < ROWS; i++)
            if (!board.row_loaded[i])
                send_request(CMD_LOAD, INDEX_W'(i), pick_word(), pick_gap());
        // back-to-back transforms against a long result hold
        if (squeeze)
        begin
            hold_request = 1'b1;
            repeat (BURST_ITEMS)
                send_request(CMD_XFORM, INDEX_W'($urandom_range(0, ROWS - 1)), $urandom(), 0);
        end
        repeat (PHASE_ITEMS) send_random_item();
        end_requests();
        phases_run++;
    endtask

    // Main sequence
    initial
    begin : stimulus
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = CMD_LOAD;
        row_index = '0;
        data      = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: narrow map, offset with upper bits that must be dropped
        write_register(REG_NARROW, 32'h0000_0001);
        write_register(REG_OFFSET, 32'hFFFF_FF5A);
        for (int i = 0; i < NARROW_W; i++)
            send_request(CMD_LOAD, INDEX_W'(i), EDGE_ROWS[i], pick_gap());
        // row index on a transform is don't-care
        for (int i = 0; i < 5; i++)
            send_request(CMD_XFORM, INDEX_W'(ROWS - 1 - i), EDGE_WORDS[i], pick_gap());
        // overwrite a row and use it at once
        send_request(CMD_LOAD, '0, 32'h0000_0001, 0);
        send_request(CMD_XFORM, '1, 32'h0000_00FF, 0);
        end_requests();

        run_phase(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1);
        run_phase($urandom(), {31'($urandom()), 1'b1}, 1'b1, 1'b0);
        run_phase($urandom(), {31'($urandom()), 1'b0}, 1'b0, 1'b0);
        run_phase(32'h0000_0000, 32'h0000_0001, 1'b1, 1'b0);
        run_phase($urandom(), 32'h0000_0000, 1'b1, 1'b0);

        wait_idle();
        board.report_leftover();
        $display("Covered %0d row loads and %0d transforms over %0d register settings,",
                 board.loads, board.transforms, phases_run + 1);
        $display("narrow and wide maps, with a long result hold; %0d results matched.",
                 board.matched);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
